// File: hdl/qse_pkg.sv
// Shared types and constants for the quicksort engine.
`timescale 1ns / 1ps

package qse_pkg;

	// Width of the value ports.
	localparam int unsigned OUT_W = 32;

	// Handshake between the sorter and the output register.
	typedef struct packed {
		logic load;  // result data on the element memory read port is valid
		logic last;  // final beat of the run
		logic ovf;   // elements were dropped in this set
	} qse_emit_t;

endpackage

// File: hdl/qse_ram.sv
// Simple dual-port synchronous RAM, one write port and one registered read port.
`timescale 1ns / 1ps

module qse_ram #(
	parameter int unsigned W = 32,
	parameter int unsigned D = 64
) (
	input  logic                 clk,
	input  logic                 we,
	input  logic [$clog2(D)-1:0] waddr,
	input  logic [W-1:0]         wdata,
	input  logic [$clog2(D)-1:0] raddr,
	output logic [W-1:0]         rdata
);

	logic [W-1:0] mem [D];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// File: hdl/qse_sorter.sv
// Sequencer: loads the set, partitions ranges from the stack, then reads the run out.
`timescale 1ns / 1ps

module qse_sorter #(
	parameter int unsigned DEPTH      = 64,
	parameter int unsigned DATA_WIDTH = 32
) (
	input  logic                          clk,
	input  logic                          arst_n,
	// input beats
	input  logic                          item_valid,
	output logic                          item_stall,
	input  logic [qse_pkg::OUT_W-1:0]     value,
	input  logic                          is_last,
	// element memory
	output logic                          e_we,
	output logic [$clog2(DEPTH)-1:0]      e_waddr,
	output logic [DATA_WIDTH-1:0]         e_wdata,
	output logic [$clog2(DEPTH)-1:0]      e_raddr,
	input  logic [DATA_WIDTH-1:0]         e_rdata,
	// range stack memory
	output logic                          s_we,
	output logic [$clog2(DEPTH)-1:0]      s_waddr,
	output logic [2*$clog2(DEPTH)-1:0]    s_wdata,
	output logic [$clog2(DEPTH)-1:0]      s_raddr,
	input  logic [2*$clog2(DEPTH)-1:0]    s_rdata,
	// output register
	output qse_pkg::qse_emit_t            emit,
	input  logic                          out_taken
);

	localparam int unsigned IW = $clog2(DEPTH);
	localparam int unsigned CW = $clog2(DEPTH + 1);
	localparam int unsigned PW = IW + 1;

	localparam logic [3:0] S_LOAD  = 4'd0;
	localparam logic [3:0] S_INIT  = 4'd1;
	localparam logic [3:0] S_POP   = 4'd2;
	localparam logic [3:0] S_POPW  = 4'd3;
	localparam logic [3:0] S_PIV   = 4'd4;
	localparam logic [3:0] S_CMP   = 4'd5;
	localparam logic [3:0] S_SW1   = 4'd6;
	localparam logic [3:0] S_SW2   = 4'd7;
	localparam logic [3:0] S_FIN   = 4'd8;
	localparam logic [3:0] S_FS1   = 4'd9;
	localparam logic [3:0] S_FS2   = 4'd10;
	localparam logic [3:0] S_PUSH1 = 4'd11;
	localparam logic [3:0] S_PUSH2 = 4'd12;
	localparam logic [3:0] S_ORD   = 4'd13;
	localparam logic [3:0] S_OLD   = 4'd14;
	localparam logic [3:0] S_OWAIT = 4'd15;

	logic [3:0]            state_q, state_d;
	logic [CW-1:0]         count_q;
	logic                  ovf_q;
	logic [CW-1:0]         sp_q;
	logic [IW-1:0]         k_q;
	logic [IW-1:0]         lo_q, hi_q, i_q, j_q;
	logic [PW-1:0]         p_q;
	logic [DATA_WIDTH-1:0] pivot_q, hold_q;

	logic is_less, i_at_hi, i_is_p, k_last, stack_room, push_lo, push_hi, j_is_lo;

	assign is_less    = $signed(e_rdata) < $signed(pivot_q);
	assign i_at_hi    = i_q == hi_q;
	assign i_is_p     = {1'b0, i_q} == p_q;
	assign k_last     = CW'(k_q) == count_q - CW'(1);
	assign stack_room = sp_q < CW'(DEPTH);
	assign j_is_lo    = IW'(p_q - PW'(1)) == lo_q;
	// left part holds at least two elements
	assign push_lo    = {1'b0, j_q} > ({1'b0, lo_q} + PW'(1));
	// right part holds at least two elements
	assign push_hi    = ({1'b0, j_q} + PW'(1)) < {1'b0, hi_q};

	assign item_stall = state_q != S_LOAD;

	always_comb begin
		state_d = state_q;
		e_we    = 1'b0;
		e_waddr = '0;
		e_wdata = hold_q;
		e_raddr = '0;
		s_we    = 1'b0;
		s_waddr = sp_q[IW-1:0];
		s_wdata = {lo_q, IW'(j_q - IW'(1))};
		s_raddr = '0;
		emit    = '0;
		case (state_q)
			S_LOAD: begin
				e_waddr = count_q[IW-1:0];
				e_wdata = DATA_WIDTH'($signed(value));
				e_we    = item_valid && (count_q < CW'(DEPTH));
				if (item_valid && is_last) begin
					state_d = S_INIT;
				end
			end
			S_INIT: begin
				s_waddr = '0;
				s_wdata = {IW'(0), IW'(count_q - CW'(1))};
				s_we    = count_q > CW'(1);
				state_d = S_POP;
			end
			S_POP: begin
				s_raddr = IW'(sp_q - CW'(1));
				state_d = (sp_q == '0) ? S_ORD : S_POPW;
			end
			S_POPW: begin
				e_raddr = s_rdata[2*IW-1:IW];
				state_d = S_PIV;
			end
			S_PIV: begin
				e_raddr = lo_q + IW'(1);
				state_d = S_CMP;
			end
			S_CMP: begin
				if (is_less && !i_is_p) begin
					e_raddr = p_q[IW-1:0];
					state_d = S_SW1;
				end else if (i_at_hi) begin
					state_d = S_FIN;
				end else begin
					e_raddr = i_q + IW'(1);
				end
			end
			S_SW1: begin
				e_we    = 1'b1;
				e_waddr = p_q[IW-1:0];
				state_d = S_SW2;
			end
			S_SW2: begin
				e_we    = 1'b1;
				e_waddr = i_q;
				if (i_at_hi) begin
					state_d = S_FIN;
				end else begin
					e_raddr = i_q + IW'(1);
					state_d = S_CMP;
				end
			end
			S_FIN: begin
				// pivot lands at p-1; nothing to swap when that is lo
				e_raddr = IW'(p_q - PW'(1));
				state_d = j_is_lo ? S_PUSH1 : S_FS1;
			end
			S_FS1: begin
				e_we    = 1'b1;
				e_waddr = lo_q;
				e_wdata = e_rdata;
				state_d = S_FS2;
			end
			S_FS2: begin
				e_we    = 1'b1;
				e_waddr = j_q;
				e_wdata = pivot_q;
				state_d = S_PUSH1;
			end
			S_PUSH1: begin
				s_we    = push_lo && stack_room;
				state_d = S_PUSH2;
			end
			S_PUSH2: begin
				s_wdata = {IW'(j_q + IW'(1)), hi_q};
				s_we    = push_hi && stack_room;
				state_d = S_POP;
			end
			S_ORD: begin
				e_raddr = k_q;
				state_d = S_OLD;
			end
			S_OLD: begin
				emit.load = 1'b1;
				emit.last = k_last;
				emit.ovf  = ovf_q;
				state_d   = S_OWAIT;
			end
			S_OWAIT: begin
				if (out_taken) begin
					state_d = k_last ? S_LOAD : S_ORD;
				end
			end
			default: begin
				state_d = S_LOAD;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_LOAD;
			count_q <= '0;
			ovf_q   <= 1'b0;
			sp_q    <= '0;
			k_q     <= '0;
		end else begin
			state_q <= state_d;
			case (state_q)
				S_LOAD: begin
					if (item_valid) begin
						if (count_q < CW'(DEPTH)) begin
							count_q <= count_q + CW'(1);
						end else begin
							ovf_q <= 1'b1;
						end
					end
				end
				S_INIT: begin
					sp_q <= (count_q > CW'(1)) ? CW'(1) : '0;
					k_q  <= '0;
				end
				S_POP: begin
					if (sp_q != '0) begin
						sp_q <= sp_q - CW'(1);
					end
				end
				S_PUSH1: begin
					if (push_lo && stack_room) begin
						sp_q <= sp_q + CW'(1);
					end
				end
				S_PUSH2: begin
					if (push_hi && stack_room) begin
						sp_q <= sp_q + CW'(1);
					end
				end
				S_OWAIT: begin
					if (out_taken) begin
						if (k_last) begin
							count_q <= '0;
							ovf_q   <= 1'b0;
						end else begin
							k_q <= k_q + IW'(1);
						end
					end
				end
				default: begin
				end
			endcase
		end
	end

	// partition datapath
	always_ff @(posedge clk) begin
		case (state_q)
			S_POPW: begin
				lo_q <= s_rdata[2*IW-1:IW];
				hi_q <= s_rdata[IW-1:0];
			end
			S_PIV: begin
				pivot_q <= e_rdata;
				i_q     <= lo_q + IW'(1);
				p_q     <= {1'b0, lo_q} + PW'(1);
			end
			S_CMP: begin
				if (is_less && !i_is_p) begin
					hold_q <= e_rdata;
				end else begin
					if (is_less) begin
						p_q <= p_q + PW'(1);
					end
					if (!i_at_hi) begin
						i_q <= i_q + IW'(1);
					end
				end
			end
			S_SW1: begin
				hold_q <= e_rdata;
			end
			S_SW2: begin
				p_q <= p_q + PW'(1);
				if (!i_at_hi) begin
					i_q <= i_q + IW'(1);
				end
			end
			S_FIN: begin
				j_q <= IW'(p_q - PW'(1));
			end
			default: begin
			end
		endcase
	end

endmodule

// File: hdl/quicksort_engine.sv
// Top level of the quicksort engine: memories, sequencer and output register.
//
// Usage:
//   Input channel (item_valid / item_stall, value, is_last) takes one beat per
//   cycle while the engine is loading. Up to DEPTH values are stored; later
//   ones are dropped and flag overflow on every result of the run. A beat with
//   is_last set closes the set and starts the sort; item_stall stays high from
//   then until the last result beat has been taken.
//   The sort is a quicksort on the first element of each range, run against
//   the element memory with a range stack memory in place of recursion. Each
//   compare and each swap goes through the single read port of the element
//   memory, one at a time. Presorted data is the worst case.
//   Output channel (result_valid / result_stall, sorted_value, is_last_res,
//   overflow) then gives the stored values in ascending order, one beat at a
//   time: the next is read only after the previous one has been taken;
//   is_last_res marks the final beat. A stall holds the beat in the output
//   register. Reset empties the engine and returns it to loading; there is no clearing pass.
`timescale 1ns / 1ps

module quicksort_engine #(
	parameter int unsigned DEPTH      = 64,
	parameter int unsigned DATA_WIDTH = 32
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      item_valid,
	output logic                      item_stall,
	input  logic signed [31:0]        value,
	input  logic                      is_last,
	output logic                      result_valid,
	input  logic                      result_stall,
	output logic signed [31:0]        sorted_value,
	output logic                      is_last_res,
	output logic                      overflow
);

	localparam int unsigned IW = $clog2(DEPTH);

	logic                  e_we;
	logic [IW-1:0]         e_waddr, e_raddr;
	logic [DATA_WIDTH-1:0] e_wdata, e_rdata;
	logic                  s_we;
	logic [IW-1:0]         s_waddr, s_raddr;
	logic [2*IW-1:0]       s_wdata, s_rdata;
	qse_pkg::qse_emit_t    emit;
	logic                  out_taken;
	logic                  result_valid_q;
	logic [31:0]           sorted_value_q;
	logic                  is_last_q, overflow_q;

	qse_ram #(.W(DATA_WIDTH), .D(DEPTH)) u_elem_ram (
		.clk   (clk),
		.we    (e_we),
		.waddr (e_waddr),
		.wdata (e_wdata),
		.raddr (e_raddr),
		.rdata (e_rdata)
	);

	qse_ram #(.W(2 * IW), .D(DEPTH)) u_stack_ram (
		.clk   (clk),
		.we    (s_we),
		.waddr (s_waddr),
		.wdata (s_wdata),
		.raddr (s_raddr),
		.rdata (s_rdata)
	);

	qse_sorter #(.DEPTH(DEPTH), .DATA_WIDTH(DATA_WIDTH)) u_sorter (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_stall (item_stall),
		.value      ($unsigned(value)),
		.is_last    (is_last),
		.e_we       (e_we),
		.e_waddr    (e_waddr),
		.e_wdata    (e_wdata),
		.e_raddr    (e_raddr),
		.e_rdata    (e_rdata),
		.s_we       (s_we),
		.s_waddr    (s_waddr),
		.s_wdata    (s_wdata),
		.s_raddr    (s_raddr),
		.s_rdata    (s_rdata),
		.emit       (emit),
		.out_taken  (out_taken)
	);

	assign out_taken = result_valid_q && !result_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (emit.load) begin
			result_valid_q <= 1'b1;
		end else if (out_taken) begin
			result_valid_q <= 1'b0;
		end
	end

	// narrow elements come out zero-extended, wide ones truncated
	always_ff @(posedge clk) begin
		if (emit.load) begin
			sorted_value_q <= qse_pkg::OUT_W'(e_rdata);
			is_last_q      <= emit.last;
			overflow_q     <= emit.ovf;
		end
	end

	assign result_valid = result_valid_q;
	assign sorted_value = $signed(sorted_value_q);
	assign is_last_res  = is_last_q;
	assign overflow     = overflow_q;

endmodule
